// ===== src/smcd_pkg.sv =====
// ----------------------------------------------------------------------------
// smcd_pkg
// Shared types, widths and helpers for the station minimum-cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package smcd_pkg;

    // Station numbering: the station fields are 4 bits wide, so the table
    // holds up to 16 stations and a cost entry is addressed as {from, to}.
    localparam int STN_W        = 4;
    localparam int MAX_STATIONS = 16;
    localparam int ADDR_W       = 2 * STN_W;
    localparam int TABLE_DEPTH  = MAX_STATIONS * MAX_STATIONS;

    // Cost widths: one ticket cost and an accumulated trip cost.
    localparam int EDGE_W = 16;
    localparam int COST_W = 20;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Item kinds.
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_ACC,
        S_DONE
    } t_state;

    // Add a ticket cost to a trip cost, saturating at the largest trip cost.
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [EDGE_W-1:0] b);
        logic [COST_W:0] sum;
        sum = {1'b0, a} + {{(COST_W-EDGE_W+1){1'b0}}, b};
        if (sum[COST_W]) begin
            return COST_MAX;
        end
        return sum[COST_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/smcd_cost_table.sv =====
// ----------------------------------------------------------------------------
// smcd_cost_table
// Ticket cost table: filters write items to forward edges inside the station
// range and stores them; one registered read port for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module smcd_cost_table
    import smcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [STN_W-1:0]  i_wr_from,
    input  wire logic [STN_W-1:0]  i_wr_to,
    input  wire logic [EDGE_W-1:0] i_wr_cost,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [EDGE_W-1:0] o_rd_cost
);

    logic [EDGE_W-1:0] r_mem [TABLE_DEPTH];
    logic              wr_ok;

    // Only forward edges between stations that exist are stored.
    assign wr_ok = i_wr_en
                && (i_wr_from < i_wr_to)
                && ({1'b0, i_wr_to} < (STN_W+1)'(MAX_STATIONS));

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[{i_wr_from, i_wr_to}] <= i_wr_cost;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rd_cost <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/station_min_cost_dp.sv =====
// ----------------------------------------------------------------------------
// station_min_cost_dp
// Cheapest trip from station 0 to a target station over a table of forward
// ticket costs, computed bottom up with one shared add/compare unit.
//
//   Channel  Signals                                         Handshake
//   -------  ----------------------------------------------  ---------------
//   input    i_action i_from_station i_to_station            start / busy
//            i_edge_cost i_target_station
//   result   o_min_cost                                      o_valid strobe
//
// A write item is taken while idle and busy stays low.
// A compute item to target t keeps busy high while every table entry (j, i)
// with j < i <= t is read and then accumulated on the single table port,
// and then the result state follows.
// o_valid is high for exactly one cycle; the receiver cannot stall it.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle; the cost
// table and best-cost array are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module station_min_cost_dp
    import smcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_action,
    input  wire logic [STN_W-1:0]  i_from_station,
    input  wire logic [STN_W-1:0]  i_to_station,
    input  wire logic [EDGE_W-1:0] i_edge_cost,
    input  wire logic [STN_W-1:0]  i_target_station,
    output logic                   o_valid,
    output logic      [COST_W-1:0] o_min_cost
);

    t_state r_state, n_state;

    logic [STN_W-1:0]  r_i;
    logic [STN_W-1:0]  r_j;
    logic [STN_W-1:0]  r_target;
    logic [COST_W-1:0] r_min;
    logic [COST_W-1:0] r_result;
    logic [COST_W-1:0] r_best [MAX_STATIONS];

    logic              accept;
    logic              wr_item;
    logic              last_j;
    logic              last_i;
    logic [EDGE_W-1:0] rd_cost;
    logic [COST_W-1:0] cand;
    logic [COST_W-1:0] new_min;
    logic [STN_W-1:0]  tgt_sat;

    assign accept  = start && !busy;
    assign wr_item = accept && (i_action == ACT_WRITE);
    assign last_j  = (r_j == r_i - STN_W'(1));
    assign last_i  = (r_i == r_target);

    // Targets past the last station saturate to it.
    assign tgt_sat = ({1'b0, i_target_station} >= (STN_W+1)'(MAX_STATIONS))
                   ? STN_W'(MAX_STATIONS - 1) : i_target_station;

    // Cost table with its registered read port addressed by {j, i}.
    smcd_cost_table u_cost_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_item),
        .i_wr_from (i_from_station),
        .i_wr_to   (i_to_station),
        .i_wr_cost (i_edge_cost),
        .i_rd_addr ({r_j, r_i}),
        .o_rd_cost (rd_cost)
    );

    // Shared add/compare unit: the direct ticket from station 0 starts the minimum,
    // and a trip through station j is compared against the running minimum.
    always_comb begin
        if (r_j == '0) begin
            cand    = {{(COST_W-EDGE_W){1'b0}}, rd_cost};
            new_min = cand;
        end else begin
            cand    = sat_add(r_best[r_j], rd_cost);
            new_min = (cand < r_min) ? cand : r_min;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ACT_COMPUTE)) begin
                    n_state = (tgt_sat == '0) ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = (last_j && last_i) ? S_DONE : S_READ;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Outputs decoded from the state.
    always_comb begin
        busy       = (r_state != S_IDLE);
        o_valid    = (r_state == S_DONE);
        o_min_cost = r_result;
    end

    // Loop counters, running minimum and best-cost array.
    always_ff @(posedge i_clk) begin
        priority case (1'b1)
            (r_state == S_IDLE) && accept && (i_action == ACT_COMPUTE): begin
                r_target <= tgt_sat;
                r_i      <= STN_W'(1);
                r_j      <= '0;
                r_result <= '0;
            end
            (r_state == S_ACC): begin
                r_min <= new_min;
                if (last_j) begin
                    r_best[r_i] <= new_min;
                    r_i         <= r_i + STN_W'(1);
                    r_j         <= '0;
                    if (last_i) begin
                        r_result <= new_min;
                    end
                end else begin
                    r_j <= r_j + STN_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Checks on the sequencer.
    a_valid_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_acc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ($past(r_state) == S_READ))
        else $error("accumulate without a preceding table read");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ACT_COMPUTE)) |=> busy)
        else $error("compute item did not make the block busy");

    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ACT_WRITE)) |=> (!busy && !o_valid))
        else $error("write item started a computation");

    a_counter_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ((r_j < r_i) && (r_i <= r_target)))
        else $error("table read outside the lower triangle");

endmodule

`default_nettype wire
